// ===== hdl/y2r_pkg.sv =====
package y2r_pkg;

	localparam int CoefRv     = 1402;
	localparam int CoefGu     = 714;
	localparam int CoefGv     = 344;
	localparam int CoefBu     = 1772;
	localparam int CoefDiv    = 1000;
	localparam int ChromaBias = 128;
	localparam int ByteMax    = 8'hFF;

	localparam int TermW = 9;   // one chroma term, -226..225
	localparam int GSumW = 10;  // sum of the two green terms
	localparam int SumW  = 11;  // luma plus terms, before clamping

	localparam logic [2:0] BytesRgb  = 3'd6;
	localparam logic [2:0] BytesGray = 3'd2;

	localparam logic [1:0] RegColorMode = 2'd0;

	typedef logic signed [TermW-1:0] term_t;
	typedef logic signed [GSumW-1:0] gsum_t;
	typedef term_t term_tab_t [256];

	typedef struct packed {
		term_t rv;
		gsum_t g;
		term_t bu;
	} chroma_terms_t;

	// (c - 128) * coef / 1000 for every chroma code, truncated toward zero;
	// with negate set the difference is taken as 128 - c.
	function automatic term_tab_t build_tab(input int coef, input bit negate);
		term_tab_t tab;
		int diff;
		for (int i = 0; i < 256; i++) begin
			diff = negate ? (ChromaBias - i) : (i - ChromaBias);
			tab[i] = TermW'((diff * coef) / CoefDiv);
		end
		return tab;
	endfunction

	localparam term_tab_t RvTab = build_tab(CoefRv, 1'b0);
	localparam term_tab_t GuTab = build_tab(CoefGu, 1'b1);
	localparam term_tab_t GvTab = build_tab(CoefGv, 1'b1);
	localparam term_tab_t BuTab = build_tab(CoefBu, 1'b0);

	function automatic logic [7:0] clamp_byte(input logic signed [SumW-1:0] s);
		logic [7:0] r;
		if (s > SumW'(ByteMax)) begin
			r = 8'(ByteMax);
		end else if (s < 0) begin
			r = 8'd0;
		end else begin
			r = s[7:0];
		end
		return r;
	endfunction

endpackage

// ===== hdl/yuyv_to_rgb24_converter.sv =====
// YUYV macropixel to RGB24 converter.
// Input stream (s_*): one item per YUYV macropixel, s_tdata = Y0, U, Y1, V
// from the low byte up, s_tlast marks the last macropixel of an image.
// Output stream (m_*): one item per input item. In color mode it carries
// R0 G0 B0 R1 G1 B1 and a byte count of 6; in grayscale mode Y0 Y1, four
// zero bytes and a count of 2. m_tlast repeats s_tlast.
// The APB port holds one register, color_mode at address 0 (bit 0).
// Write it only while no item is in flight.
// Path: an item accepted on s_* passes two register stages before it
// appears on m_*: chroma lookup, then the two pixel lanes with clamp and
// mode select. Throughput: one item per cycle while m_tready is high; each
// stage is a single table lookup or add-and-clamp.
// Stall: when m_tready is low the output holds; the lookup stage still takes
// one more item, and s_tready drops once both stages are full.
// Reset: arst_n clears both stage valid flags and sets color mode (RGB).
module yuyv_to_rgb24_converter (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // luma_first, chroma_blue, luma_second, chroma_red
	input  logic        s_tlast,  // frame_end_in
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // out_byte0..out_byte5, valid_bytes, 5 zero bits
	output logic        m_tlast   // frame_end_out
);
	import y2r_pkg::*;

	logic          color_mode_q;

	logic          valid_s1;
	logic [7:0]    y0_s1;
	logic [7:0]    y1_s1;
	chroma_terms_t terms_s1;
	logic          gray_s1;
	logic          last_s1;

	logic          valid_s2;
	logic [7:0]    bytes_s2 [6];
	logic [2:0]    count_s2;
	logic          last_s2;

	chroma_terms_t terms;
	logic [7:0]    r0, g0, b0, r1, g1, b1;
	logic          adv_s2;
	logic          adv_s1;
	logic          cfg_wr;

	// Configuration: writes land on the access cycle.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr == RegColorMode[0:0]) ? {31'd0, color_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= 1'b0;
		end else if (cfg_wr && paddr == RegColorMode[0:0]) begin
			color_mode_q <= pwdata[0];
		end
	end

	// Flow control: the output stage moves when empty or drained; the
	// lookup stage moves when it is empty or the output stage takes it.
	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;

	// Stage 1: shared chroma terms for both pixels.
	y2r_chroma u_chroma (
		.chroma_blue (s_tdata[15:8]),
		.chroma_red  (s_tdata[31:24]),
		.terms       (terms)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			y0_s1    <= s_tdata[7:0];
			y1_s1    <= s_tdata[23:16];
			terms_s1 <= terms;
			gray_s1  <= color_mode_q;
			last_s1  <= s_tlast;
		end
	end

	// Stage 2: one lane per pixel, then merge into the output word.
	y2r_lane u_lane0 (
		.luma  (y0_s1),
		.terms (terms_s1),
		.red   (r0),
		.green (g0),
		.blue  (b0)
	);

	y2r_lane u_lane1 (
		.luma  (y1_s1),
		.terms (terms_s1),
		.red   (r1),
		.green (g1),
		.blue  (b1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			last_s2 <= last_s1;
			if (gray_s1) begin
				// Luma only: pass both Y samples, zero the rest.
				bytes_s2 <= '{y0_s1, y1_s1, 8'd0, 8'd0, 8'd0, 8'd0};
				count_s2 <= BytesGray;
			end else begin
				bytes_s2 <= '{r0, g0, b0, r1, g1, b1};
				count_s2 <= BytesRgb;
			end
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tlast  = last_s2;
	assign m_tdata  = {5'd0, count_s2, bytes_s2[5], bytes_s2[4], bytes_s2[3],
		bytes_s2[2], bytes_s2[1], bytes_s2[0]};

	// A filled lookup stage moves into the output stage when it is free.
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> valid_s2)
		else $error("item lost between stages");

	// Input backpressure only when both stages hold an item and output stalls.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && !m_tready)
		else $error("input stalled with room in the pipeline");

	// The byte count is one of the two legal values.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[50:48] == BytesRgb || m_tdata[50:48] == BytesGray))
		else $error("bad byte count");

	// Grayscale items carry zeros beyond the two luma bytes.
	a_gray_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[50:48] == BytesGray |-> m_tdata[47:16] == 32'd0)
		else $error("grayscale item has nonzero padding");

endmodule

// ===== hdl/y2r_chroma.sv =====
module y2r_chroma (
	input  logic [7:0]             chroma_blue,
	input  logic [7:0]             chroma_red,
	output y2r_pkg::chroma_terms_t terms
);
	import y2r_pkg::*;

	// Look up the shared chroma offsets; the green pair is summed here so
	// the lanes see one term per channel.
	always_comb begin
		terms.rv = RvTab[chroma_red];
		terms.g  = GSumW'(GuTab[chroma_blue]) + GSumW'(GvTab[chroma_red]);
		terms.bu = BuTab[chroma_blue];
	end

endmodule

// ===== hdl/y2r_lane.sv =====
module y2r_lane (
	input  logic [7:0]             luma,
	input  y2r_pkg::chroma_terms_t terms,
	output logic [7:0]             red,
	output logic [7:0]             green,
	output logic [7:0]             blue
);
	import y2r_pkg::*;

	logic signed [SumW-1:0] y_ext;
	logic signed [SumW-1:0] r_sum;
	logic signed [SumW-1:0] g_sum;
	logic signed [SumW-1:0] b_sum;

	assign y_ext = $signed({{(SumW-8){1'b0}}, luma});
	assign r_sum = y_ext + SumW'(terms.rv);
	assign g_sum = y_ext + SumW'(terms.g);
	assign b_sum = y_ext + SumW'(terms.bu);

	assign red   = clamp_byte(r_sum);
	assign green = clamp_byte(g_sum);
	assign blue  = clamp_byte(b_sum);

endmodule
